// ===== hdl/stc_pkg.sv =====
`default_nettype none
package stc_pkg;

  // Default length of each history store in samples.
  localparam int unsigned DEPTH_DEF = 4096;

  localparam int SAMP_W    = 24;
  localparam int LFO_W     = 16;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;
  localparam int STEP_W    = 5;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIX    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXC    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TONE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_NORM   = 3'd7;

  // 0.70 and 0.65 in Q0.16.
  localparam logic [15:0] K070 = 16'd45875;
  localparam logic [15:0] K065 = 16'd42598;

  // Sequencer steps, counted from the accepting edge.
  localparam logic [STEP_W-1:0] STEP_RD_A0 = 5'd7;
  localparam logic [STEP_W-1:0] STEP_RD_A1 = 5'd8;
  localparam logic [STEP_W-1:0] STEP_RD_A2 = 5'd9;
  localparam logic [STEP_W-1:0] STEP_RD_A3 = 5'd10;
  localparam logic [STEP_W-1:0] STEP_RD_B0 = 5'd11;
  localparam logic [STEP_W-1:0] STEP_RD_B1 = 5'd12;
  localparam logic [STEP_W-1:0] STEP_TONE  = 5'd21;
  localparam logic [STEP_W-1:0] STEP_DONE  = 5'd26;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Strobes from the sequencer to the channel datapaths.
  typedef struct packed {
    logic              wr_en;
    logic              byp;
    logic              res_ld;
    logic              tone_ld;
    logic [STEP_W-1:0] step;
  } ctl_t;

  typedef struct packed {
    logic        enable;
    logic [16:0] mix;
    logic [19:0] base;
    logic [18:0] exc;
    logic [15:0] tone;
    logic [15:0] gain_a;
    logic [15:0] gain_b;
    logic [15:0] norm;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/stereo_two_tap_chorus_unit.sv =====
// Chorus on: an accepted frame runs through the sequencer steps; no new frame is taken until
// its result is loaded into the output register, which waits while the output is stalled.
// The span is set by the six history reads per channel over one read port and the chained
// multipliers behind them. Chorus off: one dry frame per cycle, unless the output stalls.
// Synchronous active-low reset restores register defaults, clears position, fill count and
// tone state; unwritten history entries read as zero, so no clearing pass is needed.
`default_nettype none
module stereo_two_tap_chorus_unit #(
  parameter int unsigned DELAY_DEPTH = stc_pkg::DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [stc_pkg::SAMP_W-1:0]     in_left_in,
  input  wire logic signed [stc_pkg::SAMP_W-1:0]     in_right_in,
  input  wire logic signed [stc_pkg::LFO_W-1:0]      in_lfo_left,
  input  wire logic signed [stc_pkg::LFO_W-1:0]      in_lfo_right,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [stc_pkg::SAMP_W-1:0]          out_left_out,
  output logic signed [stc_pkg::SAMP_W-1:0]          out_right_out,
  input  wire logic                                  cfg_wr_en,
  input  wire logic [stc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [stc_pkg::CFG_W-1:0]             cfg_wdata
);
  import stc_pkg::*;

  localparam int unsigned AW = $clog2(DELAY_DEPTH);

  // Configuration registers.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable <= 1'b0;
      cfg_r.mix    <= 17'd32768;
      cfg_r.base   <= 20'd245760;
      cfg_r.exc    <= 19'd61440;
      cfg_r.tone   <= 16'd65535;
      cfg_r.gain_a <= 16'd16384;
      cfg_r.gain_b <= 16'd16384;
      cfg_r.norm   <= 16'd16384;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ENABLE: cfg_r.enable <= cfg_wdata[0];
        CFG_MIX:    cfg_r.mix    <= cfg_wdata[16:0];
        CFG_BASE:   cfg_r.base   <= cfg_wdata[19:0];
        CFG_EXC:    cfg_r.exc    <= cfg_wdata[18:0];
        CFG_TONE:   cfg_r.tone   <= cfg_wdata[15:0];
        CFG_GAIN_A: cfg_r.gain_a <= cfg_wdata[15:0];
        CFG_GAIN_B: cfg_r.gain_b <= cfg_wdata[15:0];
        CFG_NORM:   cfg_r.norm   <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  ctl_t          ctl;
  logic [AW-1:0] wpos;
  logic [AW:0]   fill;

  stc_ctrl #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .enable    (cfg_r.enable),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .wpos      (wpos),
    .fill      (fill)
  );

  // Frame held for the duration of the computation.
  logic signed [SAMP_W-1:0] dry_l_r, dry_r_r;
  logic signed [LFO_W-1:0]  lfo_l_r, lfo_r_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      dry_l_r <= in_left_in;
      dry_r_r <= in_right_in;
      lfo_l_r <= in_lfo_left;
      lfo_r_r <= in_lfo_right;
    end
  end

  logic signed [SAMP_W-1:0] res_l, res_r;

  stc_chan #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_chan_l (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .cfg     (cfg_r),
    .wpos    (wpos),
    .fill    (fill),
    .wr_data (in_left_in),
    .dry     (dry_l_r),
    .lfo     (lfo_l_r),
    .res     (res_l)
  );

  stc_chan #(
    .DEPTH (DELAY_DEPTH),
    .AW    (AW)
  ) u_chan_r (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ctl),
    .cfg     (cfg_r),
    .wpos    (wpos),
    .fill    (fill),
    .wr_data (in_right_in),
    .dry     (dry_r_r),
    .lfo     (lfo_r_r),
    .res     (res_r)
  );

  // Output register: dry beat when bypassed, processed beat when done.
  always_ff @(posedge clk) begin
    if (ctl.byp) begin
      out_left_out  <= in_left_in;
      out_right_out <= in_right_in;
    end else if (ctl.res_ld) begin
      out_left_out  <= res_l;
      out_right_out <= res_r;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/stc_chan.sv =====
`default_nettype none
module stc_chan #(
  parameter int unsigned DEPTH = stc_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire stc_pkg::ctl_t               ctl,
  input  wire stc_pkg::cfg_t               cfg,
  input  wire logic [AW-1:0]               wpos,
  input  wire logic [AW:0]                 fill,
  input  wire logic signed [stc_pkg::SAMP_W-1:0] wr_data,
  input  wire logic signed [stc_pkg::SAMP_W-1:0] dry,
  input  wire logic signed [stc_pkg::LFO_W-1:0]  lfo,
  output logic signed [stc_pkg::SAMP_W-1:0]      res
);
  import stc_pkg::*;

  // Offset that keeps the delayed index positive before the modulo.
  localparam int OFSK  = (8192 + DEPTH - 1) / DEPTH;
  localparam int OFS   = DEPTH * OFSK;
  localparam int UMAX  = DEPTH + 2048 + OFS;
  localparam int UW    = $clog2(UMAX + 1);
  localparam int RECIP = (2 ** UW) / DEPTH;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int QW    = $clog2(UMAX / DEPTH + 2);

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] a);
    idx_inc = (a == AW'(DEPTH - 1)) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] a);
    idx_dec = (a == '0) ? AW'(DEPTH - 1) : a - 1'b1;
  endfunction

  // Delay computation for both taps.
  logic signed [35:0] pa_r, pa_nxt;
  logic        [34:0] pb1_r, pb1_nxt;
  logic        [19:0] bb_r, bb_nxt;
  logic signed [51:0] pb2_r, pb2_nxt;
  logic signed [21:0] d_r [2];
  logic signed [21:0] d_nxt [2];
  logic        [35:0] bb_full;
  logic signed [35:0] pa_sh;
  logic signed [51:0] pb2_sh;

  always_comb begin
    bb_full    = 36'(cfg.base) * 36'(K070);
    bb_nxt     = bb_full[35:16];
    pa_nxt     = 36'($signed({1'b0, cfg.exc})) * 36'(lfo);
    pb1_nxt    = 35'(cfg.exc) * 35'(K065);
    pb2_nxt    = 52'($signed({1'b0, pb1_r})) * 52'(lfo);
    pa_sh      = pa_r >>> 15;
    pb2_sh     = pb2_r >>> 31;
    d_nxt[0]   = $signed({2'b00, cfg.base}) + pa_sh[21:0];
    d_nxt[1]   = $signed({2'b00, bb_r}) - pb2_sh[21:0];
  end

  always_ff @(posedge clk) begin
    pa_r  <= pa_nxt;
    pb1_r <= pb1_nxt;
    bb_r  <= bb_nxt;
    pb2_r <= pb2_nxt;
    d_r   <= d_nxt;
  end

  // Read position: integer part reduced modulo the depth, fraction in Q0.8.
  logic [UW-1:0]    u_r [2];
  logic [UW-1:0]    u_nxt [2];
  logic [7:0]       x_r [2];
  logic [7:0]       x_nxt [2];
  logic [QW-1:0]    q_r [2];
  logic [QW-1:0]    q_nxt [2];
  logic [AW:0]      rr_r [2];
  logic [AW:0]      rr_nxt [2];
  logic [AW-1:0]    i_r [2];
  logic [AW-1:0]    i_nxt [2];
  logic [23:0]      ut [2];
  logic [UW+RW-1:0] qp [2];
  logic [UW:0]      rf [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      ut[k] = 24'(OFS) + {{(24 - AW){1'b0}}, wpos} - {{10{d_r[k][21]}}, d_r[k][21:8]}
              - {23'd0, |d_r[k][7:0]};
      u_nxt[k] = ut[k][UW-1:0];
      x_nxt[k] = 8'(~d_r[k][7:0] + 8'd1);
      qp[k] = (UW+RW)'(u_r[k]) * (UW+RW)'(RECIP);
      q_nxt[k] = QW'(qp[k] >> UW);
      rf[k] = (UW+1)'(u_r[k]) - (UW+1)'(q_r[k]) * (UW+1)'(DEPTH);
      rr_nxt[k] = rf[k][AW:0];
      i_nxt[k] = (rr_r[k] >= (AW+1)'(DEPTH)) ? AW'(rr_r[k] - (AW+1)'(DEPTH))
                                               : rr_r[k][AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    u_r  <= u_nxt;
    x_r  <= x_nxt;
    q_r  <= q_nxt;
    rr_r <= rr_nxt;
    i_r  <= i_nxt;
  end

  // History store: written on the accepting edge, read once per step.
  logic [SAMP_W-1:0] mem [DEPTH];
  logic [SAMP_W-1:0] rd_r;
  logic              rv_r;
  logic [STEP_W-1:0] rs_r;
  logic [AW-1:0]     raddr;

  always_comb begin
    case (ctl.step)
      STEP_RD_A0: raddr = idx_dec(i_r[0]);
      STEP_RD_A1: raddr = i_r[0];
      STEP_RD_A2: raddr = idx_inc(i_r[0]);
      STEP_RD_A3: raddr = idx_inc(idx_inc(i_r[0]));
      STEP_RD_B0: raddr = i_r[1];
      STEP_RD_B1: raddr = idx_inc(i_r[1]);
      default:    raddr = i_r[0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wpos] <= wr_data;
    end
    rd_r <= mem[raddr];
    rv_r <= ({1'b0, raddr} < fill);
    rs_r <= ctl.step;
  end

  // Entries never written since reset read as zero.
  logic signed [SAMP_W-1:0] smp;
  logic signed [SAMP_W-1:0] y0_r, y1_r, y2_r, y3_r, z0_r, z1_r;

  assign smp = rv_r ? $signed(rd_r) : '0;

  always_ff @(posedge clk) begin
    case (rs_r)
      STEP_RD_A0: y0_r <= smp;
      STEP_RD_A1: y1_r <= smp;
      STEP_RD_A2: y2_r <= smp;
      STEP_RD_A3: y3_r <= smp;
      STEP_RD_B0: z0_r <= smp;
      STEP_RD_B1: z1_r <= smp;
      default: ;
    endcase
  end

  // Hermite tap in Horner form and linear tap.
  logic signed [24:0] c1;
  logic signed [27:0] c2;
  logic signed [26:0] c3;
  logic signed [8:0]  xa, xb;
  logic signed [37:0] h1_r, h1_nxt;
  logic signed [47:0] h2_r, h2_nxt;
  logic signed [57:0] h3_r, h3_nxt;
  logic signed [32:0] ha_r, ha_nxt;
  logic signed [57:0] h3_sh;
  logic signed [24:0] dz;
  logic signed [33:0] lp_r, lp_nxt, lp_sh;
  logic signed [25:0] hb_r, hb_nxt;

  always_comb begin
    xa     = $signed({1'b0, x_r[0]});
    xb     = $signed({1'b0, x_r[1]});
    c1     = 25'(y2_r) - 25'(y0_r);
    c2     = 28'(y0_r) * 28'sd2 - 28'(y1_r) * 28'sd5 + 28'(y2_r) * 28'sd4 - 28'(y3_r);
    c3     = 27'(y3_r) - 27'(y0_r) + (27'(y1_r) - 27'(y2_r)) * 27'sd3;
    h1_nxt = 38'(c3) * 38'(xa) + (38'(c2) <<< 8);
    h2_nxt = 48'(h1_r) * 48'(xa) + (48'(c1) <<< 16);
    h3_nxt = 58'(h2_r) * 58'(xa) + (58'(y1_r) <<< 25);
    h3_sh  = (h3_r + 58'sd16777216) >>> 25;
    ha_nxt = h3_sh[32:0];
    dz     = 25'(z1_r) - 25'(z0_r);
    lp_nxt = 34'(dz) * 34'(xb);
    lp_sh  = (lp_r + 34'sd128) >>> 8;
    hb_nxt = 26'(z0_r) + lp_sh[25:0];
  end

  always_ff @(posedge clk) begin
    h1_r <= h1_nxt;
    h2_r <= h2_nxt;
    h3_r <= h3_nxt;
    ha_r <= ha_nxt;
    lp_r <= lp_nxt;
    hb_r <= hb_nxt;
  end

  // Tap weighting and tone filter.
  logic signed [49:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic signed [50:0] tsum;
  logic signed [36:0] tap_r, tap_nxt;
  logic signed [37:0] df_r, df_nxt;
  logic signed [54:0] tp_r, tp_nxt, tp_sh;
  logic signed [39:0] tn;
  logic signed [31:0] tone_r, tone_nxt;

  always_comb begin
    ma_nxt  = 50'(ha_r) * 50'($signed({1'b0, cfg.gain_a}));
    mb_nxt  = 50'(hb_r) * 50'($signed({1'b0, cfg.gain_b}));
    tsum    = (51'(ma_r) + 51'(mb_r) + 51'sd8192) >>> 14;
    tap_nxt = tsum[36:0];
    df_nxt  = 38'(tap_r) - 38'(tone_r);
    tp_nxt  = 55'(df_r) * 55'($signed({1'b0, cfg.tone}));
    tp_sh   = (tp_r + 55'sd32768) >>> 16;
    tn      = 40'(tone_r) + tp_sh[39:0];
    if (tn > 40'sd2147483647) begin
      tone_nxt = 32'sh7FFFFFFF;
    end else if (tn < -40'sd2147483648) begin
      tone_nxt = 32'sh80000000;
    end else begin
      tone_nxt = tn[31:0];
    end
  end

  always_ff @(posedge clk) begin
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    tap_r <= tap_nxt;
    df_r  <= df_nxt;
    tp_r  <= tp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_r <= '0;
    end else if (ctl.tone_ld) begin
      tone_r <= tone_nxt;
    end
  end

  // Crossfade with the dry sample, output gain and saturation.
  logic [16:0]        mcl;
  logic signed [32:0] md_r, md_nxt;
  logic signed [50:0] mp_r, mp_nxt, mp_sh;
  logic signed [35:0] mx_r, mx_nxt;
  logic signed [52:0] op_r, op_nxt, op_sh;

  always_comb begin
    mcl    = (cfg.mix > 17'd65536) ? 17'd65536 : cfg.mix;
    md_nxt = 33'(tone_r) - 33'(dry);
    mp_nxt = 51'(md_r) * 51'($signed({1'b0, mcl}));
    mp_sh  = (mp_r + 51'sd32768) >>> 16;
    mx_nxt = 36'(dry) + mp_sh[35:0];
    op_nxt = 53'(mx_r) * 53'($signed({1'b0, cfg.norm}));
    op_sh  = (op_r + 53'sd8192) >>> 14;
    if (op_sh > 53'sd8388607) begin
      res = 24'sh7FFFFF;
    end else if (op_sh < -53'sd8388608) begin
      res = 24'sh800000;
    end else begin
      res = op_sh[23:0];
    end
  end

  always_ff @(posedge clk) begin
    md_r <= md_nxt;
    mp_r <= mp_nxt;
    mx_r <= mx_nxt;
    op_r <= op_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/stc_ctrl.sv =====
`default_nettype none
module stc_ctrl #(
  parameter int unsigned DEPTH = stc_pkg::DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          enable,
  input  wire logic          in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  output stc_pkg::ctl_t      ctl,
  output logic [AW-1:0]      wpos,
  output logic [AW:0]        fill
);
  import stc_pkg::*;

  state_t            state_r, state_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]     w_r, w_nxt;
  logic [AW:0]       fill_r, fill_nxt;
  logic              ov_r, ov_nxt;
  logic              accept, done;

  // Handshake: one frame in flight, output register frees the input side.
  assign in_stall  = (state_r != ST_IDLE) || (ov_r && out_stall);
  assign accept    = in_valid && !in_stall;
  assign done      = (state_r == ST_RUN) && (cnt_r == STEP_DONE) && (!ov_r || !out_stall);
  assign out_valid = ov_r;
  assign wpos      = w_r;
  assign fill      = fill_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept && enable) state_nxt = ST_RUN;
      ST_RUN:  if (done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    ctl.wr_en   = accept;
    ctl.byp     = accept && !enable;
    ctl.res_ld  = done;
    ctl.tone_ld = (state_r == ST_RUN) && (cnt_r == STEP_TONE);
    ctl.step    = cnt_r;
  end

  // Step counter, write position, fill count and output flag.
  always_comb begin
    cnt_nxt = cnt_r;
    if (accept) begin
      cnt_nxt = STEP_W'(1);
    end else if ((state_r == ST_RUN) && (cnt_r != STEP_DONE)) begin
      cnt_nxt = cnt_r + 1'b1;
    end
    w_nxt = w_r;
    if (ctl.byp || done) begin
      w_nxt = (w_r == AW'(DEPTH - 1)) ? '0 : w_r + 1'b1;
    end
    fill_nxt = fill_r;
    if (accept && (fill_r != (AW+1)'(DEPTH))) begin
      fill_nxt = fill_r + 1'b1;
    end
    ov_nxt = ov_r;
    if (ctl.byp || done) begin
      ov_nxt = 1'b1;
    end else if (ov_r && !out_stall) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      w_r     <= '0;
      fill_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      w_r     <= w_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
    end
  end

endmodule
`default_nettype wire
